[hdl/lhpd_pkg.sv]
package lhpd_pkg;

  localparam int unsigned MAX_HITS_DEFAULT = 384;
  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] MAGIC_EVEN = 8'h9C;
  localparam logic [7:0] MAGIC_ODD = 8'hAD;
  localparam logic [15:0] POS_LIMIT = 16'd40000;
  localparam logic [15:0] POS_CENTRE = 16'd20000;
  localparam logic [7:0] ID_LIMIT = 8'd31;

  localparam logic [2:0] MAGIC_LAST = 3'd7;
  localparam logic [2:0] COUNT_LAST = 3'd3;
  localparam logic [2:0] TIME_LAST = 3'd7;
  localparam logic [2:0] PAD_LAST = 3'd3;
  localparam logic [2:0] HIT_SKIP = 3'd6;
  localparam logic [2:0] HIT_ID = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_COUNT,
    PH_TIME,
    PH_PAD,
    PH_HIT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_HITS      = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_ID        = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_t;

  // Packed result as it sits in the queue.
  typedef struct packed {
    kind_t              kind;
    logic [63:0]        timestamp_us;
    logic [8:0]         hit_total;
    logic signed [15:0] forward_ticks;
    logic signed [15:0] left_ticks;
    logic signed [15:0] up_ticks;
    err_t               error_code;
    logic               last_of_packet;
  } result_t;

  // Layout of the output tdata, lowest field last in the declaration.
  typedef struct packed {
    logic [3:0]         fill;
    err_t               error_code;
    logic signed [15:0] up_ticks;
    logic signed [15:0] left_ticks;
    logic signed [15:0] forward_ticks;
    logic [8:0]         hit_total;
    logic [63:0]        timestamp_us;
  } out_data_t;

endpackage

[hdl/lhpd_front.sv]
module lhpd_front #(
  parameter int unsigned MAX_HITS = lhpd_pkg::MAX_HITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  output logic              push,
  output lhpd_pkg::result_t res
);

  localparam int unsigned HW = $clog2(MAX_HITS + 1);

  lhpd_pkg::phase_t phase, phase_next;
  logic [2:0]       pos, pos_next;
  logic             mismatch, mismatch_next;
  logic [HW-1:0]    hits_left, hits_left_next;
  logic [23:0]      count_asm, count_asm_next;
  logic [63:0]      time_asm, time_asm_next;
  logic [7:0]       low_hold, low_hold_next;
  logic [15:0]      held_left, held_left_next;
  logic [15:0]      held_forward, held_forward_next;
  logic [15:0]      held_up, held_up_next;

  logic        want_bad;
  logic [31:0] full_count;
  logic        count_bad;
  logic [15:0] raw;
  logic [15:0] ticks;
  logic        raw_bad;
  logic        id_bad;
  logic        hit_odd;
  logic        last_hit;

  assign want_bad   = data_byte != (pos[0] ? lhpd_pkg::MAGIC_ODD : lhpd_pkg::MAGIC_EVEN);
  assign full_count = {data_byte, count_asm};
  assign count_bad  = full_count > 32'(MAX_HITS);
  assign raw        = {data_byte, low_hold};
  assign ticks      = lhpd_pkg::POS_CENTRE - raw;
  assign raw_bad    = raw > lhpd_pkg::POS_LIMIT;
  assign id_bad     = data_byte > lhpd_pkg::ID_LIMIT;
  assign hit_odd    = pos[0] && (pos != lhpd_pkg::HIT_ID);
  assign last_hit   = hits_left == HW'(1);

  // Next state and assembly registers.
  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    mismatch_next     = mismatch;
    hits_left_next    = hits_left;
    count_asm_next    = count_asm;
    time_asm_next     = time_asm;
    low_hold_next     = low_hold;
    held_left_next    = held_left;
    held_forward_next = held_forward;
    held_up_next      = held_up;
    if (take) begin
      if (end_of_input) begin
        phase_next    = lhpd_pkg::PH_HUNT;
        pos_next      = '0;
        mismatch_next = 1'b0;
      end else begin
        unique case (phase)
          lhpd_pkg::PH_HUNT: begin
            pos_next      = pos + 3'd1;
            mismatch_next = mismatch | want_bad;
            if (pos == lhpd_pkg::MAGIC_LAST) begin
              mismatch_next = 1'b0;
              if (!(mismatch | want_bad)) begin
                phase_next = lhpd_pkg::PH_COUNT;
              end
            end
          end
          lhpd_pkg::PH_COUNT: begin
            // Little-endian bytes shift in from the top.
            count_asm_next = {data_byte, count_asm[23:8]};
            pos_next       = pos + 3'd1;
            if (pos == lhpd_pkg::COUNT_LAST) begin
              pos_next = '0;
              if (count_bad) begin
                phase_next = lhpd_pkg::PH_HUNT;
              end else begin
                phase_next     = lhpd_pkg::PH_TIME;
                hits_left_next = HW'(full_count);
              end
            end
          end
          lhpd_pkg::PH_TIME: begin
            time_asm_next = {data_byte, time_asm[63:8]};
            pos_next      = pos + 3'd1;
            if (pos == lhpd_pkg::TIME_LAST) begin
              phase_next = lhpd_pkg::PH_PAD;
              pos_next   = '0;
            end
          end
          lhpd_pkg::PH_PAD: begin
            pos_next = pos + 3'd1;
            if (pos == lhpd_pkg::PAD_LAST) begin
              pos_next   = '0;
              phase_next = (hits_left == '0) ? lhpd_pkg::PH_HUNT : lhpd_pkg::PH_HIT;
            end
          end
          lhpd_pkg::PH_HIT: begin
            pos_next = pos + 3'd1;
            if (pos == lhpd_pkg::HIT_ID) begin
              pos_next = '0;
              if (id_bad) begin
                phase_next = lhpd_pkg::PH_HUNT;
              end else begin
                hits_left_next = hits_left - HW'(1);
                if (last_hit) begin
                  phase_next = lhpd_pkg::PH_HUNT;
                end
              end
            end else if (hit_odd) begin
              if (raw_bad) begin
                phase_next = lhpd_pkg::PH_HUNT;
                pos_next   = '0;
              end else begin
                unique case (pos[2:1])
                  2'd0:    held_left_next = ticks;
                  2'd1:    held_forward_next = ticks;
                  default: held_up_next = ticks;
                endcase
              end
            end else if (pos != lhpd_pkg::HIT_SKIP) begin
              low_hold_next = data_byte;
            end
          end
          default: begin
            phase_next    = lhpd_pkg::PH_HUNT;
            pos_next      = '0;
            mismatch_next = 1'b0;
          end
        endcase
      end
    end
  end

  // Result produced by the transfer just taken.
  always_comb begin
    push = 1'b0;
    res  = '0;
    if (take) begin
      if (end_of_input) begin
        if (!(phase == lhpd_pkg::PH_HUNT && pos == '0)) begin
          push           = 1'b1;
          res.kind       = lhpd_pkg::KIND_ERROR;
          res.error_code = lhpd_pkg::ERR_TRUNCATED;
        end
      end else begin
        unique case (phase)
          lhpd_pkg::PH_HUNT: begin
            if (pos == lhpd_pkg::MAGIC_LAST && (mismatch | want_bad)) begin
              push           = 1'b1;
              res.kind       = lhpd_pkg::KIND_ERROR;
              res.error_code = lhpd_pkg::ERR_MAGIC;
            end
          end
          lhpd_pkg::PH_COUNT: begin
            if (pos == lhpd_pkg::COUNT_LAST && count_bad) begin
              push           = 1'b1;
              res.kind       = lhpd_pkg::KIND_ERROR;
              res.error_code = lhpd_pkg::ERR_HITS;
            end
          end
          lhpd_pkg::PH_PAD: begin
            if (pos == lhpd_pkg::PAD_LAST) begin
              push             = 1'b1;
              res.kind         = lhpd_pkg::KIND_HEADER;
              res.timestamp_us = time_asm;
              res.hit_total    = 9'(hits_left);
            end
          end
          lhpd_pkg::PH_HIT: begin
            if (pos == lhpd_pkg::HIT_ID) begin
              push = 1'b1;
              if (id_bad) begin
                res.kind       = lhpd_pkg::KIND_ERROR;
                res.error_code = lhpd_pkg::ERR_ID;
              end else begin
                res.kind          = lhpd_pkg::KIND_POINT;
                res.forward_ticks = $signed(held_forward);
                res.left_ticks    = $signed(held_left);
                res.up_ticks      = $signed(held_up);
              end
            end else if (hit_odd && raw_bad) begin
              push           = 1'b1;
              res.kind       = lhpd_pkg::KIND_ERROR;
              res.error_code = lhpd_pkg::ERR_RANGE;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
      // Errors always close the packet; a header closes it when no hits follow, a point on the final hit.
      if (res.kind == lhpd_pkg::KIND_ERROR) begin
        res.last_of_packet = 1'b1;
      end else if (res.kind == lhpd_pkg::KIND_HEADER) begin
        res.last_of_packet = hits_left == '0;
      end else begin
        res.last_of_packet = last_hit;
      end
      if (!push) begin
        res = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lhpd_pkg::PH_HUNT;
      pos       <= '0;
      mismatch  <= 1'b0;
      hits_left <= '0;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      mismatch  <= mismatch_next;
      hits_left <= hits_left_next;
    end
  end

  always_ff @(posedge clk) begin
    count_asm    <= count_asm_next;
    time_asm     <= time_asm_next;
    low_hold     <= low_hold_next;
    held_left    <= held_left_next;
    held_forward <= held_forward_next;
    held_up      <= held_up_next;
  end

endmodule

[hdl/lhpd_queue.sv]
module lhpd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lhpd_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output lhpd_pkg::result_t head,
  output logic              full
);

  localparam int unsigned AW = $clog2(lhpd_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(lhpd_pkg::QDEPTH + 1);

  lhpd_pkg::result_t entries [lhpd_pkg::QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] fill;

  assign head_valid = fill != '0;
  assign head       = entries[rptr];
  assign full       = fill == CW'(lhpd_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + AW'(1);
      end
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

[hdl/lhpd_back.sv]
module lhpd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  lhpd_pkg::result_t head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [127:0]      m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  lhpd_pkg::out_data_t packed_data;

  assign pop = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    packed_data               = '0;
    packed_data.timestamp_us  = head.timestamp_us;
    packed_data.hit_total     = head.hit_total;
    packed_data.forward_ticks = head.forward_ticks;
    packed_data.left_ticks    = head.left_ticks;
    packed_data.up_ticks      = head.up_ticks;
    packed_data.error_code    = head.error_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= packed_data;
      m_tuser <= head.kind;
      m_tlast <= head.last_of_packet;
    end
  end

endmodule

[hdl/lidar_hit_packet_deframer.sv]
// A byte that completes a header, point or error is written into the result queue at its own
// transfer and reaches m_tdata from there through the output register.
// Throughput: one byte per cycle; s_tready drops only while the four-entry result queue is full.
// Reset: rst is synchronous and active high; it returns the parser to hunting for the magic
// and empties the queue and the output register. No clearing pass follows reset.
module lidar_hit_packet_deframer #(
  parameter int unsigned MAX_HITS = lhpd_pkg::MAX_HITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // [7:0] data_byte
  input  logic         s_tlast,  // end_of_input
  output logic         m_tvalid,
  input  logic         m_tready,
  // [63:0] timestamp_us, [72:64] hit_total, [88:73] forward_ticks, [104:89] left_ticks,
  // [120:105] up_ticks, [123:121] error_code, [127:124] zero
  output logic [127:0] m_tdata,
  output logic [1:0]   m_tuser,  // [1:0] result_kind
  output logic         m_tlast   // last_of_packet
);

  logic              take;
  logic              push;
  lhpd_pkg::result_t push_data;
  logic              pop;
  logic              head_valid;
  lhpd_pkg::result_t head;
  logic              full;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  lhpd_front #(
    .MAX_HITS(MAX_HITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (s_tdata),
    .end_of_input(s_tlast),
    .push        (push),
    .res         (push_data)
  );

  lhpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .full      (full)
  );

  lhpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[hdl/lhpd_checker.sv]
module lhpd_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);

  lhpd_pkg::out_data_t od;

  assign od = m_tdata;

  // A stalled result must hold until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lhpd_pkg::KIND_ERROR |->
      m_tlast && od.error_code != lhpd_pkg::ERR_NONE && od.timestamp_us == '0
      && od.forward_ticks == '0 && od.left_ticks == '0 && od.up_ticks == '0)
    else $error("malformed error result");

  a_point_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lhpd_pkg::KIND_POINT |->
      od.timestamp_us == '0 && od.hit_total == '0 && od.error_code == lhpd_pkg::ERR_NONE)
    else $error("point result carries header or error fields");

  a_empty_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lhpd_pkg::KIND_HEADER && od.hit_total == '0 |-> m_tlast)
    else $error("header of an empty packet does not close it");

endmodule

bind lidar_hit_packet_deframer lhpd_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

[bench/testbench.sv]
module testbench;

  localparam int unsigned MAX_HITS = lhpd_pkg::MAX_HITS_DEFAULT;

  typedef enum {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_COUNT,
    FLAW_RANGE,
    FLAW_ID,
    FLAW_CUT
  } flaw_t;

  typedef struct {
    logic [7:0]  data;
    bit          eoi;
    int unsigned gap;
    bit          drain;
  } stream_byte_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  lidar_hit_packet_deframer #(
    .MAX_HITS(MAX_HITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Parser state mirrored from the block.
  lhpd_pkg::phase_t   ph = lhpd_pkg::PH_HUNT;
  logic [3:0]         bpos = '0;
  bit                 mism = 1'b0;
  logic [8:0]         hits_left = '0;
  logic [31:0]        count_acc = '0;
  logic [63:0]        stamp_acc = '0;
  logic [7:0]         low_hold = '0;
  logic signed [15:0] held_left = '0;
  logic signed [15:0] held_fwd = '0;
  logic signed [15:0] held_up = '0;

  stream_byte_t       byte_queue[$];
  lhpd_pkg::result_t  expected_results[$];
  stream_byte_t       cur_byte;
  lhpd_pkg::result_t  predicted;
  lhpd_pkg::result_t  seen;
  lhpd_pkg::result_t  wanted;
  int unsigned   gap_cap = 0;
  bit            drain_next = 1'b0;
  bit            offering = 1'b0;
  bit            in_taken = 1'b0;
  bit            out_taken = 1'b0;
  bit            long_hold = 1'b0;
  int unsigned   idle_count = 0;
  int unsigned   sink_wait = 0;
  int unsigned   bytes_in = 0;
  int unsigned   results_seen = 0;
  int unsigned   input_stalls = 0;
  int unsigned   faults = 0;
  int unsigned   kind_count[3] = '{0, 0, 0};
  bit [7:0]      codes_seen = '0;

  function automatic void rehunt();
    ph = lhpd_pkg::PH_HUNT;
    bpos = '0;
    mism = 1'b0;
  endfunction

  function automatic lhpd_pkg::result_t error_result(input lhpd_pkg::err_t code);
    lhpd_pkg::result_t r;
    r = '0;
    rehunt();
    r.kind = lhpd_pkg::KIND_ERROR;
    r.error_code = code;
    r.last_of_packet = 1'b1;
    return r;
  endfunction

  // Advances the mirrored parser by one transfer; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input bit eoi,
                                    output lhpd_pkg::result_t r);
    logic [15:0] raw;
    logic [15:0] ticks;
    bit          last;
    r = '0;
    if (eoi) begin
      if (ph == lhpd_pkg::PH_HUNT && bpos == 4'd0) return 1'b0;
      r = error_result(lhpd_pkg::ERR_TRUNCATED);
      return 1'b1;
    end
    case (ph)
      lhpd_pkg::PH_HUNT: begin
        if (b != (bpos[0] ? lhpd_pkg::MAGIC_ODD : lhpd_pkg::MAGIC_EVEN)) mism = 1'b1;
        bpos++;
        if (bpos == 4'd8) begin
          if (mism) begin
            r = error_result(lhpd_pkg::ERR_MAGIC);
            return 1'b1;
          end
          ph = lhpd_pkg::PH_COUNT;
          bpos = '0;
          count_acc = '0;
        end
        return 1'b0;
      end
      lhpd_pkg::PH_COUNT: begin
        count_acc |= 32'(b) << (8 * bpos[1:0]);
        bpos++;
        if (bpos == 4'd4) begin
          if (count_acc > MAX_HITS) begin
            r = error_result(lhpd_pkg::ERR_HITS);
            return 1'b1;
          end
          hits_left = count_acc[8:0];
          ph = lhpd_pkg::PH_TIME;
          bpos = '0;
          stamp_acc = '0;
        end
        return 1'b0;
      end
      lhpd_pkg::PH_TIME: begin
        stamp_acc |= 64'(b) << (8 * bpos[2:0]);
        bpos++;
        if (bpos == 4'd8) begin
          ph = lhpd_pkg::PH_PAD;
          bpos = '0;
        end
        return 1'b0;
      end
      lhpd_pkg::PH_PAD: begin
        bpos++;
        if (bpos != 4'd4) return 1'b0;
        last = (hits_left == 0);
        if (last) begin
          rehunt();
        end else begin
          ph = lhpd_pkg::PH_HIT;
          bpos = '0;
        end
        r.kind = lhpd_pkg::KIND_HEADER;
        r.timestamp_us = stamp_acc;
        r.hit_total = hits_left;
        r.last_of_packet = last;
        return 1'b1;
      end
      lhpd_pkg::PH_HIT: begin
        case (bpos)
          4'd0, 4'd2, 4'd4: begin
            low_hold = b;
            bpos++;
            return 1'b0;
          end
          4'd1, 4'd3, 4'd5: begin
            raw = {b, low_hold};
            if (raw > lhpd_pkg::POS_LIMIT) begin
              r = error_result(lhpd_pkg::ERR_RANGE);
              return 1'b1;
            end
            ticks = lhpd_pkg::POS_CENTRE - raw;
            if (bpos == 4'd1) held_left = ticks;
            else if (bpos == 4'd3) held_fwd = ticks;
            else held_up = ticks;
            bpos++;
            return 1'b0;
          end
          4'd6: begin
            bpos++;
            return 1'b0;
          end
          default: begin
            if (b > lhpd_pkg::ID_LIMIT) begin
              r = error_result(lhpd_pkg::ERR_ID);
              return 1'b1;
            end
            if (hits_left > 0) hits_left--;
            last = (hits_left == 0);
            if (last) rehunt();
            else bpos = '0;
            r.kind = lhpd_pkg::KIND_POINT;
            r.forward_ticks = held_fwd;
            r.left_ticks = held_left;
            r.up_ticks = held_up;
            r.last_of_packet = last;
            return 1'b1;
          end
        endcase
      end
      default: begin
        rehunt();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string show(input lhpd_pkg::result_t r);
    return $sformatf("kind %0d ts %h total %0d fwd %0d left %0d up %0d err %0d last %0d",
                     r.kind, r.timestamp_us, r.hit_total, r.forward_ticks, r.left_ticks,
                     r.up_ticks, r.error_code, r.last_of_packet);
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic put_byte(input logic [7:0] b, input bit eoi);
    stream_byte_t it;
    it.data = b;
    it.eoi = eoi;
    it.gap = $urandom_range(0, gap_cap);
    it.drain = drain_next;
    drain_next = 1'b0;
    byte_queue = {byte_queue, it};
  endtask

  // Builds one packet, optionally spoilt or cut short; a spoilt packet ends right after the flaw.
  task automatic put_packet(input int unsigned hits, input logic [31:0] count,
                            input logic [63:0] stamp, input flaw_t flaw, input bit extremes);
    logic [7:0]  pkt[$];
    logic [7:0]  nb;
    logic [15:0] raw;
    int unsigned keep;
    int unsigned h;
    int unsigned a;
    for (int i = 0; i < 8; i++) begin
      nb = (i % 2) ? lhpd_pkg::MAGIC_ODD : lhpd_pkg::MAGIC_EVEN;
      pkt = {pkt, nb};
    end
    for (int i = 0; i < 4; i++) pkt = {pkt, count[8*i +: 8]};
    for (int i = 0; i < 8; i++) pkt = {pkt, stamp[8*i +: 8]};
    for (int i = 0; i < 4; i++) pkt = {pkt, 8'($urandom)};
    for (int i = 0; i < hits; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (extremes) begin
          case ((i + j) % 3)
            0: raw = 16'd0;
            1: raw = lhpd_pkg::POS_LIMIT;
            default: raw = lhpd_pkg::POS_CENTRE;
          endcase
        end else begin
          case ($urandom_range(0, 9))
            0: raw = 16'd0;
            1: raw = lhpd_pkg::POS_LIMIT;
            default: raw = 16'($urandom_range(0, 40000));
          endcase
        end
        pkt = {pkt, raw[7:0]};
        pkt = {pkt, raw[15:8]};
      end
      pkt = {pkt, 8'($urandom)};
      nb = extremes ? ((i % 2) ? lhpd_pkg::ID_LIMIT : 8'd0) : 8'($urandom_range(0, 31));
      pkt = {pkt, nb};
    end
    keep = pkt.size();
    case (flaw)
      FLAW_MAGIC: begin
        h = $urandom_range(0, 7);
        pkt[h] = pkt[h] ^ 8'($urandom_range(1, 255));
        keep = 8;
      end
      FLAW_COUNT: keep = 12;
      FLAW_RANGE: begin
        h = $urandom_range(0, hits - 1);
        a = $urandom_range(0, 2);
        raw = 16'($urandom_range(40001, 65535));
        pkt[24 + 8*h + 2*a] = raw[7:0];
        pkt[24 + 8*h + 2*a + 1] = raw[15:8];
        keep = 24 + 8*h + 2*a + 2;
      end
      FLAW_ID: begin
        h = $urandom_range(0, hits - 1);
        pkt[24 + 8*h + 7] = 8'($urandom_range(32, 255));
        keep = 24 + 8*h + 8;
      end
      FLAW_CUT: keep = $urandom_range(1, pkt.size() - 1);
      default: ;
    endcase
    for (int i = 0; i < keep; i++) put_byte(pkt[i], 1'b0);
    if (flaw == FLAW_CUT) put_byte(8'($urandom), 1'b1);
  endtask

  // Source side: a byte flagged for draining is held back until nothing is outstanding.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        offering = 1'b0;
        idle_count = 0;
      end
      if (!offering && byte_queue.size() > 0) begin
        if (idle_count < byte_queue[0].gap) begin
          idle_count++;
        end else if (!byte_queue[0].drain || expected_results.size() == 0) begin
          cur_byte = byte_queue.pop_front();
          offering = 1'b1;
        end
      end
      s_tvalid <= offering;
      s_tdata <= cur_byte.data;
      s_tlast <= cur_byte.eoi;
    end
  end

  // Sink side: quiet stretches come and go with the number of results seen.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 1'b0;
        sink_wait = $urandom_range(0, ((results_seen / 40) % 3 == 2) ? 0 : 15);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !long_hold;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stalls++;
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        bytes_in++;
        if (parse_byte(s_tdata, s_tlast, predicted))
          expected_results = {expected_results, predicted};
      end
      if (m_tvalid && m_tready) begin
        out_taken = 1'b1;
        results_seen++;
        seen.kind = lhpd_pkg::kind_t'(m_tuser);
        seen.timestamp_us = m_tdata[63:0];
        seen.hit_total = m_tdata[72:64];
        seen.forward_ticks = m_tdata[88:73];
        seen.left_ticks = m_tdata[104:89];
        seen.up_ticks = m_tdata[120:105];
        seen.error_code = lhpd_pkg::err_t'(m_tdata[123:121]);
        seen.last_of_packet = m_tlast;
        if (m_tuser <= 2'd2) kind_count[m_tuser]++;
        codes_seen[m_tdata[123:121]] = 1'b1;
        if (expected_results.size() == 0) begin
          note_fault({"unexpected result: ", show(seen)});
        end else begin
          wanted = expected_results.pop_front();
          if (seen !== wanted || m_tdata[127:124] !== 4'd0)
            note_fault({"got ", show(seen), " fill ", $sformatf("%h", m_tdata[127:124]),
                        "; expected ", show(wanted)});
        end
      end
    end
  end

  // Long hold-off on the result side so that the queue fills and the input backs up.
  initial begin
    @(negedge rst);
    while (bytes_in < 250) @(posedge clk);
    long_hold = 1'b1;
    repeat (600) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned random_bytes;
    int unsigned start_size;
    int unsigned pick;
    logic [31:0] bad_count;

    // Directed part.
    gap_cap = 2;
    put_byte(8'($urandom), 1'b1);
    put_packet(0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, FLAW_NONE, 1'b0);
    drain_next = 1'b1;
    put_packet(2, 32'd2, 64'd0, FLAW_NONE, 1'b1);
    put_packet(1, 32'd1, {$urandom, $urandom}, FLAW_NONE, 1'b1);
    put_packet(0, 32'd0, 64'd0, FLAW_MAGIC, 1'b0);
    put_packet(0, MAX_HITS + 1, 64'd0, FLAW_COUNT, 1'b0);
    put_packet(0, 32'hFFFF_FFFF, 64'd0, FLAW_COUNT, 1'b0);
    put_packet(2, 32'd2, {$urandom, $urandom}, FLAW_RANGE, 1'b0);
    put_packet(2, 32'd2, {$urandom, $urandom}, FLAW_ID, 1'b0);
    put_byte(lhpd_pkg::MAGIC_EVEN, 1'b0);
    put_byte(8'($urandom), 1'b1);
    // A full-size count is only announced; the stream ends after two hits.
    put_packet(2, MAX_HITS, {$urandom, $urandom}, FLAW_NONE, 1'b0);
    put_byte(8'($urandom), 1'b1);

    // Random part: mostly well-formed packets, some spoilt ones and some noise.
    random_bytes = 0;
    while (random_bytes < 680) begin
      start_size = byte_queue.size();
      pick = $urandom_range(0, 9);
      gap_cap = (pick < 4) ? 15 : (pick < 7) ? 3 : 0;
      drain_next = ($urandom_range(0, 19) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pick = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
        put_packet(pick, pick, {$urandom, $urandom}, FLAW_NONE, 1'b0);
      end else if (pick < 68) begin
        put_packet(0, 32'd0, 64'd0, FLAW_MAGIC, 1'b0);
      end else if (pick < 72) begin
        if ($urandom_range(0, 1)) bad_count = $urandom_range(MAX_HITS + 1, 1023);
        else bad_count = {8'($urandom_range(1, 255)), 24'($urandom)};
        put_packet(0, bad_count, 64'd0, FLAW_COUNT, 1'b0);
      end else if (pick < 78) begin
        pick = $urandom_range(1, 3);
        put_packet(pick, pick, {$urandom, $urandom}, FLAW_RANGE, 1'b0);
      end else if (pick < 84) begin
        pick = $urandom_range(1, 3);
        put_packet(pick, pick, {$urandom, $urandom}, FLAW_ID, 1'b0);
      end else if (pick < 92) begin
        pick = $urandom_range(0, 3);
        put_packet(pick, pick, {$urandom, $urandom}, FLAW_CUT, 1'b0);
      end else begin
        repeat ($urandom_range(1, 20)) put_byte(8'($urandom), 1'b0);
        if ($urandom_range(0, 3) == 0) put_byte(8'($urandom), 1'b1);
      end
      random_bytes += byte_queue.size() - start_size;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || offering) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      note_fault($sformatf("%0d results never arrived", expected_results.size()));

    $display("run covered %0d bytes in and %0d results out (%0d headers, %0d points, %0d errors)",
             bytes_in, results_seen, kind_count[0], kind_count[1], kind_count[2]);
    $display("error codes seen %b, input held off for %0d cycles, %0d mismatches",
             codes_seen, input_stalls, faults);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lhpd_pkg.sv
hdl/lhpd_front.sv
hdl/lhpd_queue.sv
hdl/lhpd_back.sv
hdl/lidar_hit_packet_deframer.sv
hdl/lhpd_checker.sv
bench/testbench.sv
